[hw/rtl/pfsm_pkg.sv]
// pfsm_pkg: shared types, codes and reset link table for the programmable fsm block
// used by programmable_fsm_with_reachability_top; depends on nothing
`timescale 1ns / 1ps

package pfsm_pkg;

    // default configuration
    localparam int PFSM_NUM_STATES = 8;
    localparam int PFSM_ROOT_STATE = 4;

    // port field widths
    localparam int PFSM_MODE_W   = 3;
    localparam int PFSM_IDX_W    = 3;
    localparam int PFSM_STATUS_W = 2;
    localparam int PFSM_MASK_W   = 8;

    typedef logic [PFSM_MODE_W-1:0]   t_mode;
    typedef logic [PFSM_STATUS_W-1:0] t_status;

    // command codes
    localparam t_mode MODE_STEP     = 3'd0;
    localparam t_mode MODE_RETARGET = 3'd1;
    localparam t_mode MODE_QUERY    = 3'd2;
    localparam t_mode MODE_DELETE   = 3'd3;
    localparam t_mode MODE_PRUNE    = 3'd4;

    // result status codes
    localparam t_status ST_DONE = 2'd0;
    localparam t_status ST_NONE = 2'd1;
    localparam t_status ST_DEAD = 2'd2;

    // reset destinations, link 0 then link 1 for states A..H
    localparam logic [3:0] PFSM_RESET_DEST [16] = '{
        4'd6, 4'd7, 4'd2, 4'd5, 4'd4, 4'd6, 4'd1, 4'd4,
        4'd0, 4'd1, 4'd7, 4'd2, 4'd5, 4'd0, 4'd3, 4'd7
    };

    // reset value of one link: {valid, dest}
    function automatic logic [4:0] pfsm_reset_link(input int idx, input int n);
        logic [4:0] res;
        res = '0;
        if (idx < 16) begin
            if (int'(PFSM_RESET_DEST[idx[3:0]]) < n) begin
                res = {1'b1, PFSM_RESET_DEST[idx[3:0]]};
            end
        end
        return res;
    endfunction

endpackage

[hw/rtl/pfsm_ram.sv]
// pfsm_ram: generic simple dual-port ram, one write and one registered read port
// standalone, no package dependency
`timescale 1ns / 1ps

module pfsm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/programmable_fsm_with_reachability_top.sv]
// programmable_fsm_with_reachability_top: programmable state machine with link table,
// reachability walk and state deletion; uses pfsm_pkg and pfsm_ram
`timescale 1ns / 1ps

// Command interface: an item is taken when start is high and busy is low; its result
// appears for exactly one cycle with o_done high and cannot be held off. Retarget, a
// rejected delete and unused modes answer the cycle after the item and never raise busy.
// A step reads its link in the S_STEP state and then answers. Queries walk the reachable
// states from the root through the single read port of the link memory, reading both
// links of each state in turn. A named delete sweeps every link once; bulk delete is a
// walk followed by that sweep when something is unreachable. No clearing pass after
// reset: links read their reset value from a constant table until first written.
module programmable_fsm_with_reachability_top #(
    parameter int NUM_STATES = pfsm_pkg::PFSM_NUM_STATES,
    parameter int ROOT_STATE = pfsm_pkg::PFSM_ROOT_STATE
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [pfsm_pkg::PFSM_MODE_W-1:0]   i_mode,
    input  logic                               i_input_bit,
    input  logic [pfsm_pkg::PFSM_IDX_W-1:0]    i_target_state,
    input  logic [pfsm_pkg::PFSM_IDX_W-1:0]    i_state_index,
    output logic                               o_done,
    output logic [pfsm_pkg::PFSM_IDX_W-1:0]    o_cur_state,
    output logic [pfsm_pkg::PFSM_STATUS_W-1:0] o_status,
    output logic [pfsm_pkg::PFSM_MASK_W-1:0]   o_unreachable_mask,
    output logic [pfsm_pkg::PFSM_MASK_W-1:0]   o_deleted_mask
);

    import pfsm_pkg::*;

    localparam int SW       = $clog2(NUM_STATES);
    localparam int AW       = SW + 1;
    localparam int CW       = AW + 1;
    localparam int NLINKS   = 2 * NUM_STATES;
    localparam int ROOT_IDX = (ROOT_STATE < NUM_STATES) ? ROOT_STATE : 0;

    localparam logic [NUM_STATES-1:0] ONE_N     = NUM_STATES'(1);
    localparam logic [NUM_STATES-1:0] ROOT_ONE  = ONE_N << ROOT_IDX;
    localparam logic [CW-1:0]         SWEEP_END = CW'(NLINKS);

    // sequencer codes
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_STEP  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_SWEEP = 2'd3;

    // control state
    logic [1:0]            r_fsm,     n_fsm;
    logic [SW-1:0]         r_ps,      n_ps;
    logic [NUM_STATES-1:0] r_del,     n_del;
    logic [NLINKS-1:0]     r_mark,    n_mark;
    logic [NUM_STATES-1:0] r_visited, n_visited;
    logic [NUM_STATES-1:0] r_expd,    n_expd;
    logic                  r_pend,    n_pend;
    logic                  r_k,       n_k;
    logic                  r_bulk,    n_bulk;
    logic [CW-1:0]         r_cnt,     n_cnt;
    logic                  r_done,    n_done;

    // payload
    logic [SW-1:0]         r_cur,     n_cur;
    logic [NUM_STATES-1:0] r_kill,    n_kill;
    logic [NUM_STATES-1:0] r_unr,     n_unr;
    t_status               r_status,  n_status;
    logic [AW-1:0]         r_rd_addr;

    // memory port
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wa;
    logic [SW:0]   wd;
    logic [SW:0]   ram_q;

    // resolved link read
    logic [4:0]            rst_link;
    logic                  d_valid;
    logic [SW-1:0]         d_dest;
    logic                  d_ok;
    logic [NUM_STATES-1:0] seen_fwd;
    logic [NUM_STATES-1:0] frontier;
    logic [NUM_STATES-1:0] unreach_w;
    logic [SW-1:0]         pick;
    logic                  tgt_ok;
    logic                  idx_ok;

    pfsm_ram #(
        .WIDTH (SW + 1),
        .DEPTH (NLINKS)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wa),
        .i_wdata (wd),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // a link never written reads its reset value
    always_comb begin
        rst_link = pfsm_reset_link(int'(r_rd_addr), NUM_STATES);
        if (r_mark[r_rd_addr]) begin
            d_valid = ram_q[SW];
            d_dest  = ram_q[SW-1:0];
        end else begin
            d_valid = rst_link[4];
            d_dest  = rst_link[SW-1:0];
        end
        d_ok = d_valid && (32'(d_dest) < NUM_STATES);
    end

    // walk frontier with the arriving link folded in
    always_comb begin
        seen_fwd = r_visited;
        if (r_pend && d_ok) begin
            seen_fwd = r_visited | (ONE_N << d_dest);
        end
        frontier  = seen_fwd & ~r_expd;
        unreach_w = ~seen_fwd & ~r_del;
        pick      = '0;
        for (int i = NUM_STATES - 1; i >= 0; i--) begin
            if (frontier[i]) begin
                pick = SW'(i);
            end
        end
    end

    // command operand checks
    assign tgt_ok = (32'(i_target_state) < NUM_STATES) &&
                    !(|(r_del & (ONE_N << i_target_state)));
    assign idx_ok = (32'(i_state_index) < NUM_STATES) &&
                    !(|(r_del & (ONE_N << i_state_index)));

    // sequencer
    always_comb begin
        n_fsm     = r_fsm;
        n_ps      = r_ps;
        n_del     = r_del;
        n_mark    = r_mark;
        n_visited = r_visited;
        n_expd    = r_expd;
        n_pend    = 1'b0;
        n_k       = r_k;
        n_bulk    = r_bulk;
        n_cnt     = r_cnt;
        n_done    = 1'b0;
        n_cur     = r_cur;
        n_kill    = r_kill;
        n_unr     = r_unr;
        n_status  = r_status;
        rd_addr   = {r_ps, i_input_bit};
        we        = 1'b0;
        wa        = r_rd_addr;
        wd        = {1'b0, d_dest};

        unique case (r_fsm)
            S_IDLE: begin
                if (start) begin
                    unique case (i_mode)
                        MODE_STEP: begin
                            n_fsm = S_STEP;
                        end
                        MODE_RETARGET: begin
                            n_done = 1'b1;
                            n_unr  = '0;
                            if (tgt_ok) begin
                                we         = 1'b1;
                                wa         = {r_ps, i_input_bit};
                                wd         = {1'b1, SW'(i_target_state)};
                                n_mark[wa] = 1'b1;
                                n_status   = ST_DONE;
                            end else begin
                                n_status = ST_NONE;
                            end
                        end
                        MODE_QUERY, MODE_PRUNE: begin
                            n_fsm     = S_WALK;
                            n_visited = ROOT_ONE;
                            n_expd    = '0;
                            n_k       = 1'b0;
                            n_bulk    = (i_mode == MODE_PRUNE);
                        end
                        MODE_DELETE: begin
                            n_unr = '0;
                            if (idx_ok) begin
                                n_kill   = ONE_N << i_state_index;
                                n_status = ST_DONE;
                                n_cnt    = '0;
                                n_fsm    = S_SWEEP;
                            end else begin
                                n_status = ST_NONE;
                                n_done   = 1'b1;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_unr    = '0;
                            n_status = ST_NONE;
                        end
                    endcase
                end
            end

            S_STEP: begin
                n_done = 1'b1;
                n_fsm  = S_IDLE;
                n_unr  = '0;
                if (d_ok) begin
                    n_ps     = d_dest;
                    n_status = ST_DONE;
                end else begin
                    n_status = ST_DEAD;
                end
            end

            S_WALK: begin
                n_visited = seen_fwd;
                if (r_k) begin
                    // second link of the state being expanded
                    rd_addr = {r_cur, 1'b1};
                    n_pend  = 1'b1;
                    n_k     = 1'b0;
                end else if (|frontier) begin
                    rd_addr = {pick, 1'b0};
                    n_cur   = pick;
                    n_expd  = r_expd | (ONE_N << pick);
                    n_k     = 1'b1;
                    n_pend  = 1'b1;
                end else begin
                    n_unr    = unreach_w;
                    n_status = (|unreach_w) ? ST_DONE : ST_NONE;
                    if (r_bulk && (|unreach_w)) begin
                        n_kill = unreach_w;
                        n_cnt  = '0;
                        n_fsm  = S_SWEEP;
                    end else begin
                        n_done = 1'b1;
                        n_fsm  = S_IDLE;
                    end
                end
            end

            S_SWEEP: begin
                // read one link a cycle, drop it on the next if it points at a victim
                if (r_cnt < SWEEP_END) begin
                    rd_addr = r_cnt[AW-1:0];
                    n_cnt   = r_cnt + CW'(1);
                    n_pend  = 1'b1;
                end
                if (r_pend && d_ok && (|(r_kill & (ONE_N << d_dest)))) begin
                    we                = 1'b1;
                    wa                = r_rd_addr;
                    wd                = {1'b0, d_dest};
                    n_mark[r_rd_addr] = 1'b1;
                end
                if (!r_pend && (r_cnt == SWEEP_END)) begin
                    n_del  = r_del | r_kill;
                    n_done = 1'b1;
                    n_fsm  = S_IDLE;
                end
            end

            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= S_IDLE;
            r_ps      <= SW'(ROOT_IDX);
            r_del     <= '0;
            r_mark    <= '0;
            r_visited <= '0;
            r_expd    <= '0;
            r_pend    <= 1'b0;
            r_k       <= 1'b0;
            r_bulk    <= 1'b0;
            r_cnt     <= '0;
            r_done    <= 1'b0;
        end else begin
            r_fsm     <= n_fsm;
            r_ps      <= n_ps;
            r_del     <= n_del;
            r_mark    <= n_mark;
            r_visited <= n_visited;
            r_expd    <= n_expd;
            r_pend    <= n_pend;
            r_k       <= n_k;
            r_bulk    <= n_bulk;
            r_cnt     <= n_cnt;
            r_done    <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_kill    <= n_kill;
        r_unr     <= n_unr;
        r_status  <= n_status;
        r_rd_addr <= rd_addr;
    end

    // result item
    assign busy               = (r_fsm != S_IDLE);
    assign o_done             = r_done;
    assign o_cur_state        = PFSM_IDX_W'(r_ps);
    assign o_status           = r_status;
    assign o_unreachable_mask = PFSM_MASK_W'(r_unr);
    assign o_deleted_mask     = PFSM_MASK_W'(r_del);

`ifndef SYNTHESIS
    // present state always names a real state
    a_ps_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ps) < NUM_STATES)
        else $error("present state out of range");

    // only states already seen are ever expanded by the walk
    a_expd_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_WALK) |-> ((r_expd & ~r_visited) == '0))
        else $error("walk expanded an unseen state");

    // deletion is permanent
    a_del_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (($past(r_del) & ~r_del) == '0))
        else $error("deleted flag cleared");

    // a result follows an accepted item or a running command
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(start && !busy) || $past(r_fsm != S_IDLE)))
        else $error("result without a command");
`endif

endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for programmable_fsm_with_reachability_top
// drives step, retarget, query, delete and prune commands and unused modes and checks each result
// against an in-bench link table predictor; depends on pfsm_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
    import pfsm_pkg::*;

    localparam int N_STATES   = PFSM_NUM_STATES;
    localparam int ROOT_IDX   = PFSM_ROOT_STATE;
    localparam int N_LINKS    = 2 * N_STATES;
    localparam int N_RANDOM   = 550;
    localparam int DRAIN_CYC  = 80;

    typedef logic [PFSM_IDX_W-1:0]  t_idx;
    typedef logic [PFSM_MASK_W-1:0] t_mask;

    // one command item as it sits on the input ports
    typedef struct packed {
        t_mode mode;
        logic  sym;
        t_idx  target;
        t_idx  victim;
    } t_fsm_cmd;

    // one result item as it comes back on the output ports
    typedef struct packed {
        t_idx    cur;
        t_status status;
        t_mask   unreach;
        t_mask   gone;
    } t_fsm_res;

    // reset destinations, link 0 then link 1 for states A..H
    localparam t_idx RESET_DST [16] = '{
        3'd6, 3'd7, 3'd2, 3'd5, 3'd4, 3'd6, 3'd1, 3'd4,
        3'd0, 3'd1, 3'd7, 3'd2, 3'd5, 3'd0, 3'd3, 3'd7
    };

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_fsm_cmd cur_cmd = '0;
    logic     o_done;
    t_idx     o_cur_state;
    t_status  o_status;
    t_mask    o_unreachable_mask;
    t_mask    o_deleted_mask;

    // predicted machine: link table, deleted flags, present state
    logic     link_ok  [N_LINKS];
    t_idx     link_dst [N_LINKS];
    t_mask    dead_states;
    t_idx     here;

    t_fsm_cmd pending_cmds [$];
    t_fsm_res expected_res [$];
    int       n_total;
    int       n_accepted;
    int       n_checked;
    int       n_errors;
    int       mode_hits [8];

    programmable_fsm_with_reachability_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (cur_cmd.mode),
        .i_input_bit        (cur_cmd.sym),
        .i_target_state     (cur_cmd.target),
        .i_state_index      (cur_cmd.victim),
        .o_done             (o_done),
        .o_cur_state        (o_cur_state),
        .o_status           (o_status),
        .o_unreachable_mask (o_unreachable_mask),
        .o_deleted_mask     (o_deleted_mask)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // live-or-dead set of states reachable from the root over valid links
    function automatic t_mask reach_set();
        t_mask seen;
        seen = '0;
        seen[ROOT_IDX] = 1'b1;
        for (int pass = 0; pass < N_STATES; pass++) begin
            for (int s = 0; s < N_STATES; s++) begin
                if (seen[s]) begin
                    for (int k = 0; k < 2; k++) begin
                        if (link_ok[2*s+k]) seen[link_dst[2*s+k]] = 1'b1;
                    end
                end
            end
        end
        return seen;
    endfunction

    // mark a state deleted and drop every link that lands on it
    task automatic drop_state(input int victim);
        dead_states[victim] = 1'b1;
        for (int i = 0; i < N_LINKS; i++) begin
            if (link_ok[i] && link_dst[i] == t_idx'(victim)) link_ok[i] = 1'b0;
        end
    endtask

    // apply one command to the predicted machine and form its result
    task automatic predict_cmd(input t_fsm_cmd c, output t_fsm_res r);
        int    slot;
        t_mask lost;
        slot = 2 * int'(here) + int'(c.sym);
        lost = '0;
        r.status = ST_NONE;
        case (c.mode)
            MODE_STEP: begin
                if (link_ok[slot]) begin
                    here = link_dst[slot];
                    r.status = ST_DONE;
                end else begin
                    r.status = ST_DEAD;
                end
            end
            MODE_RETARGET: begin
                if (!dead_states[c.target]) begin
                    link_ok[slot]  = 1'b1;
                    link_dst[slot] = c.target;
                    r.status = ST_DONE;
                end
            end
            MODE_QUERY, MODE_PRUNE: begin
                lost = ~reach_set() & ~dead_states;
                if (lost != '0) r.status = ST_DONE;
                if (c.mode == MODE_PRUNE) begin
                    for (int s = 0; s < N_STATES; s++) begin
                        if (lost[s]) drop_state(s);
                    end
                end
            end
            MODE_DELETE: begin
                if (!dead_states[c.victim]) begin
                    drop_state(int'(c.victim));
                    r.status = ST_DONE;
                end
            end
            default: ;
        endcase
        r.cur = here;
        r.unreach = lost;
        r.gone = dead_states;
    endtask

    // compare one result field and report a mismatch
    task automatic check_field(input string fname, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, exp_v, act_v);
        end
    endtask

    // random command, deletions kept rare until the last fifth of the run
    function automatic t_fsm_cmd rand_cmd(input int k);
        t_fsm_cmd c;
        int       pick;
        bit       late;
        late = (k >= (N_RANDOM * 4) / 5);
        pick = $urandom_range(0, 199);
        c.sym    = 1'($urandom_range(0, 1));
        c.target = t_idx'($urandom_range(0, 7));
        c.victim = t_idx'($urandom_range(0, 7));
        if (pick < 90) c.mode = MODE_STEP;
        else if (pick < 150) c.mode = MODE_RETARGET;
        else if (pick < 176) c.mode = MODE_QUERY;
        else if (pick < 182) c.mode = t_mode'($urandom_range(5, 7));
        else if (pick < (late ? 191 : 185)) c.mode = MODE_DELETE;
        else if (pick < (late ? 200 : 188)) c.mode = MODE_PRUNE;
        else c.mode = MODE_STEP;
        return c;
    endfunction

    // driver: record accepted items, then offer the next one or idle
    always @(posedge i_clk) begin
        t_fsm_res exp_r;
        int       idle_pct;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_cmd(cur_cmd, exp_r);
                expected_res.push_back(exp_r);
                mode_hits[cur_cmd.mode]++;
                n_accepted++;
            end
            if (!(start && busy)) begin
                if (n_accepted < n_total / 3) idle_pct = 16;
                else if (n_accepted < (2 * n_total) / 3) idle_pct = 52;
                else idle_pct = 0;
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    cur_cmd <= pending_cmds.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed result is checked against the oldest prediction
    always @(posedge i_clk) begin
        t_fsm_res exp_r;
        if (i_rst_n && o_done) begin
            if (expected_res.size() == 0) begin
                n_errors++;
                $display("%0t: result with nothing expected, state %0d status %0d",
                         $time, o_cur_state, o_status);
            end else begin
                exp_r = expected_res.pop_front();
                n_checked++;
                check_field("cur_state", exp_r.cur, o_cur_state);
                check_field("status", exp_r.status, o_status);
                check_field("unreachable_mask", exp_r.unreach, o_unreachable_mask);
                check_field("deleted_mask", exp_r.gone, o_deleted_mask);
            end
        end
    end

    // directed item helper
    task automatic add_cmd(input t_mode m, input logic s, input int tgt, input int vic);
        t_fsm_cmd c;
        c.mode = m;
        c.sym = s;
        c.target = t_idx'(tgt);
        c.victim = t_idx'(vic);
        pending_cmds.push_back(c);
    endtask

    // stimulus, reset and end of run
    initial begin
        n_accepted = 0;
        n_checked = 0;
        n_errors = 0;
        foreach (mode_hits[m]) mode_hits[m] = 0;
        for (int i = 0; i < N_LINKS; i++) begin
            link_ok[i]  = (i < 16);
            link_dst[i] = (i < 16) ? RESET_DST[i] : '0;
        end
        dead_states = '0;
        here = t_idx'(ROOT_IDX);

        // directed: full reach, steps, a cut link, pruning, rejections,
        // unused modes, deleted present state and deleted root
        add_cmd(MODE_QUERY, 1'b0, 0, 0);
        add_cmd(MODE_STEP, 1'b0, 0, 0);
        add_cmd(MODE_STEP, 1'b1, 7, 7);
        add_cmd(MODE_RETARGET, 1'b0, 7, 0);
        add_cmd(MODE_QUERY, 1'b1, 7, 7);
        add_cmd(MODE_PRUNE, 1'b0, 0, 0);
        add_cmd(MODE_DELETE, 1'b0, 0, 3);
        add_cmd(MODE_RETARGET, 1'b0, 3, 0);
        add_cmd(t_mode'(5), 1'b1, 7, 7);
        add_cmd(t_mode'(6), 1'b0, 0, 0);
        add_cmd(t_mode'(7), 1'b1, 7, 7);
        add_cmd(MODE_DELETE, 1'b1, 7, 7);
        add_cmd(MODE_STEP, 1'b1, 0, 0);
        add_cmd(MODE_STEP, 1'b0, 0, 0);
        add_cmd(MODE_RETARGET, 1'b0, 0, 0);
        add_cmd(MODE_STEP, 1'b0, 0, 0);
        add_cmd(MODE_RETARGET, 1'b1, 1, 0);
        add_cmd(MODE_DELETE, 1'b0, 0, 4);
        add_cmd(MODE_QUERY, 1'b0, 0, 0);
        add_cmd(MODE_PRUNE, 1'b1, 7, 7);
        add_cmd(MODE_STEP, 1'b1, 7, 7);
        for (int k = 0; k < N_RANDOM; k++) pending_cmds.push_back(rand_cmd(k));
        n_total = pending_cmds.size();

        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("covered %0d items: %0d step, %0d retarget, %0d query, %0d delete, %0d prune",
                 n_accepted, mode_hits[MODE_STEP], mode_hits[MODE_RETARGET],
                 mode_hits[MODE_QUERY], mode_hits[MODE_DELETE], mode_hits[MODE_PRUNE]);
        $display("%0d results checked, %0d mismatches, final deleted set %b",
                 n_checked, n_errors, dead_states);
        if (n_errors == 0 && expected_res.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_res.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[programmable_fsm_with_reachability_top.f]
hw/rtl/pfsm_pkg.sv
hw/rtl/pfsm_ram.sv
hw/rtl/programmable_fsm_with_reachability_top.sv
tb/tb_top.sv
